/* hdl/rpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_pkg
// shared widths, types and register indexes of the rigid point transform
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int WORD_W    = 32;  // Q16.16 coordinates and dual part
  localparam int ROT_W     = 16;  // Q2.14 real part
  localparam int CFG_IDX_W = 4;
  localparam int NUM_AXES  = 3;
  localparam int TDATA_W   = NUM_AXES * WORD_W;

  localparam int FRAC_SH   = 14;
  localparam int RND_HALF  = 8192;

  localparam int PROD_W    = ROT_W + WORD_W;   // u * p, w * d
  localparam int CROSS_W   = PROD_W + 2;       // 2 * (a - b)
  localparam int E_W       = CROSS_W - FRAC_SH;
  localparam int TRAN_W    = PROD_W + 4;
  localparam int RPROD_W   = ROT_W + E_W;
  localparam int SUM_W     = 56;
  localparam int Q_W       = SUM_W - FRAC_SH;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ROT_W-1:0]  rot_t;

  typedef struct packed {
    rot_t              w;
    rot_t  [2:0]       u;
    word_t             dw;
    word_t [2:0]       d;
  } xform_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_W  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_W = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_X = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_Y = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_Z = CFG_IDX_W'(7);

  localparam rot_t ROT_ONE = 16'sd16384;

endpackage

/* hdl/rpt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_datapath
// five-stage arithmetic pipeline: cross and translation products, rounding of
// e and translation sum, rotation products, rounded sum, shift and saturation
// ----------------------------------------------------------------------------
module rpt_datapath (
  input  logic                 clk,
  input  rpt_pkg::stage_en_t   en,
  input  rpt_pkg::xform_t      xf,
  input  rpt_pkg::word_t [2:0] point,
  output rpt_pkg::word_t [2:0] moved,
  output logic                 clipped
);

  // stage 1
  rpt_pkg::word_t                      p1  [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::PROD_W-1:0]   pa1 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::PROD_W-1:0]   pb1 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::PROD_W-1:0]   wd1 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::PROD_W-1:0]   du1 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::PROD_W-1:0]   da1 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::PROD_W-1:0]   db1 [rpt_pkg::NUM_AXES];
  // stage 2
  rpt_pkg::word_t                      p2  [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::E_W-1:0]      e2  [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::TRAN_W-1:0]   t2  [rpt_pkg::NUM_AXES];
  // stage 3
  rpt_pkg::word_t                      p3  [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::TRAN_W-1:0]   t3  [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::RPROD_W-1:0]  we3 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::RPROD_W-1:0]  ea3 [rpt_pkg::NUM_AXES];
  logic signed [rpt_pkg::RPROD_W-1:0]  eb3 [rpt_pkg::NUM_AXES];
  // stage 4
  logic signed [rpt_pkg::SUM_W-1:0]    s4  [rpt_pkg::NUM_AXES];
  // stage 5
  rpt_pkg::word_t                      m5  [rpt_pkg::NUM_AXES];
  logic [rpt_pkg::NUM_AXES-1:0]        clip5;

  for (genvar i = 0; i < rpt_pkg::NUM_AXES; i++) begin : g_axis
    localparam int A = (i + 1) % rpt_pkg::NUM_AXES;
    localparam int B = (i + 2) % rpt_pkg::NUM_AXES;

    logic signed [rpt_pkg::CROSS_W-1:0] c2;
    logic signed [rpt_pkg::TRAN_W-1:0]  tsum;
    logic signed [rpt_pkg::Q_W-1:0]     q;

    // 2 * (u x p) and 2 * (w*d - dw*u + u x d)
    assign c2 = (rpt_pkg::CROSS_W'(pa1[i]) - rpt_pkg::CROSS_W'(pb1[i])) <<< 1;
    assign tsum = (rpt_pkg::TRAN_W'(wd1[i]) - rpt_pkg::TRAN_W'(du1[i])
                 + rpt_pkg::TRAN_W'(da1[i]) - rpt_pkg::TRAN_W'(db1[i])) <<< 1;
    assign q = rpt_pkg::Q_W'(s4[i] >>> rpt_pkg::FRAC_SH);

    always_ff @(posedge clk) begin
      if (en.s1) begin
        p1[i]  <= point[i];
        pa1[i] <= xf.u[A] * point[B];
        pb1[i] <= xf.u[B] * point[A];
        wd1[i] <= xf.w * xf.d[i];
        du1[i] <= xf.dw * xf.u[i];
        da1[i] <= xf.u[A] * xf.d[B];
        db1[i] <= xf.u[B] * xf.d[A];
      end
      if (en.s2) begin
        p2[i] <= p1[i];
        e2[i] <= rpt_pkg::E_W'((c2 + rpt_pkg::CROSS_W'(rpt_pkg::RND_HALF))
                                >>> rpt_pkg::FRAC_SH);
        t2[i] <= tsum;
      end
      if (en.s3) begin
        p3[i]  <= p2[i];
        t3[i]  <= t2[i];
        we3[i] <= xf.w * e2[i];
        ea3[i] <= xf.u[A] * e2[B];
        eb3[i] <= xf.u[B] * e2[A];
      end
      if (en.s4) begin
        s4[i] <= (rpt_pkg::SUM_W'(p3[i]) <<< rpt_pkg::FRAC_SH)
               + rpt_pkg::SUM_W'(we3[i])
               + rpt_pkg::SUM_W'(ea3[i]) - rpt_pkg::SUM_W'(eb3[i])
               + rpt_pkg::SUM_W'(t3[i])
               + rpt_pkg::SUM_W'(rpt_pkg::RND_HALF);
      end
      if (en.s5) begin
        priority if (q > rpt_pkg::Q_W'(rpt_pkg::WORD_MAX)) begin
          m5[i]    <= rpt_pkg::WORD_MAX;
          clip5[i] <= 1'b1;
        end else if (q < rpt_pkg::Q_W'(rpt_pkg::WORD_MIN)) begin
          m5[i]    <= rpt_pkg::WORD_MIN;
          clip5[i] <= 1'b1;
        end else begin
          m5[i]    <= rpt_pkg::WORD_W'(q);
          clip5[i] <= 1'b0;
        end
      end
    end

    assign moved[i] = m5[i];
  end

  assign clipped = |clip5;

endmodule

/* hdl/rigid_point_transform_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_point_transform_core
// rigid transform of a point stream by a dual quaternion held in registers
// ----------------------------------------------------------------------------
// usage:
//   the eight transform registers (rot_w..rot_z in Q2.14, dual_w..dual_z in
//   Q16.16) are written through cfg_we / cfg_index / cfg_data while no point
//   is in flight; indexes above 7 are ignored
//   points enter on s_tvalid / s_tready / s_tdata, one per transaction
//   results leave on m_tvalid / m_tready / m_tdata / m_tuser, where m_tuser
//   flags a saturated coordinate
//   a point accepted at one clock edge passes five register stages, the
//   first loaded at the accepting edge, and is shown on m_tdata once the
//   fifth stage holds it
//   throughput: one point per clock unless stalled, set by fully pipelined multipliers
//   a stalled receiver holds the output stage; each earlier stage keeps
//   filling until it is occupied, so s_tready falls only when all five
//   stages hold points
//   reset clears the valid flag of every stage and loads the identity transform
// ----------------------------------------------------------------------------
module rigid_point_transform_core (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rpt_pkg::TDATA_W-1:0]       s_tdata,  // point_x, point_y, point_z
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rpt_pkg::TDATA_W-1:0]       m_tdata,  // moved_x, moved_y, moved_z
  output logic                              m_tuser,  // clipped
  // configuration
  input  logic                              cfg_we,
  input  logic [rpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpt_pkg::WORD_W-1:0]        cfg_data
);

  rpt_pkg::xform_t      xf;
  rpt_pkg::stage_en_t   en;
  rpt_pkg::word_t [2:0] point;
  rpt_pkg::word_t [2:0] moved;
  logic [5:1]           vld;
  logic [5:1]           rdy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      xf <= '{w: rpt_pkg::ROT_ONE, u: '0, dw: '0, d: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpt_pkg::REG_ROT_W:  xf.w    <= rpt_pkg::ROT_W'(cfg_data);
        rpt_pkg::REG_ROT_X:  xf.u[0] <= rpt_pkg::ROT_W'(cfg_data);
        rpt_pkg::REG_ROT_Y:  xf.u[1] <= rpt_pkg::ROT_W'(cfg_data);
        rpt_pkg::REG_ROT_Z:  xf.u[2] <= rpt_pkg::ROT_W'(cfg_data);
        rpt_pkg::REG_DUAL_W: xf.dw   <= cfg_data;
        rpt_pkg::REG_DUAL_X: xf.d[0] <= cfg_data;
        rpt_pkg::REG_DUAL_Y: xf.d[1] <= cfg_data;
        rpt_pkg::REG_DUAL_Z: xf.d[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage ready, bubbles collapse
  assign rdy[5] = !vld[5] || m_tready;
  assign rdy[4] = !vld[4] || rdy[5];
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_tvalid;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
    end
  end

  assign en.s1 = rdy[1];
  assign en.s2 = rdy[2];
  assign en.s3 = rdy[3];
  assign en.s4 = rdy[4];
  assign en.s5 = rdy[5];

  assign point = s_tdata;

  rpt_datapath u_datapath (
    .clk     (clk),
    .en      (en),
    .xf      (xf),
    .point   (point),
    .moved   (moved),
    .clipped (m_tuser)
  );

  assign s_tready = rdy[1];
  assign m_tvalid = vld[5];
  assign m_tdata  = moved;

endmodule

/* hdl/rpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_checker
// port-level checks of the rigid point transform, bound to the top level
// ----------------------------------------------------------------------------
module rpt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rpt_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tuser
);

  // pipeline is empty right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a free output stage means the input side can take a transaction
  assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output stage is free");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output transaction changed");

  // clipped flag only with a coordinate at a range limit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[31:0]  == rpt_pkg::WORD_MAX || m_tdata[31:0]  == rpt_pkg::WORD_MIN ||
      m_tdata[63:32] == rpt_pkg::WORD_MAX || m_tdata[63:32] == rpt_pkg::WORD_MIN ||
      m_tdata[95:64] == rpt_pkg::WORD_MAX || m_tdata[95:64] == rpt_pkg::WORD_MIN)
    else $error("clipped set with no saturated coordinate");

endmodule

bind rigid_point_transform_core rpt_checker u_rpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
